[rtl/core/fpss_pkg.sv]
// ----------------------------------------------------------------------------
// fpss_pkg
// Shared widths, register codes and types of the five-point stencil sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpss_pkg;

  // Payload and register field widths
  localparam int SAMPLE_W  = 32;
  localparam int COLS_W    = 11;
  localparam int ROWS_W    = 16;
  localparam int ROW_POS_W = 17;
  localparam int CFG_IDX_W = 1;

  // Line length limit and register reset values
  localparam int MAX_COLS_DEFAULT = 1024;
  localparam logic [COLS_W-1:0] GRID_COLS_RESET = COLS_W'(1024);
  localparam logic [ROWS_W-1:0] GRID_ROWS_RESET = ROWS_W'(1024);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLS = 1'b0,
    REG_GRID_ROWS = 1'b1
  } cfg_reg_t;

  // Per-position status from the raster scanner
  typedef struct packed {
    logic produce;   // current position is an interior cell with all neighbors
    logic last;      // final interior cell of the grid
  } scan_flags_t;

endpackage

`default_nettype wire

[rtl/core/fpss_sample_if.sv]
// ----------------------------------------------------------------------------
// fpss_sample_if
// Valid/ready channel carrying one padded grid sample per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fpss_sample_if;
  import fpss_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

[rtl/core/fpss_result_if.sv]
// ----------------------------------------------------------------------------
// fpss_result_if
// Valid/ready channel carrying one interior result per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fpss_result_if;
  import fpss_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] value;
  logic                       last_of_sweep;

  modport source (output valid, output value, output last_of_sweep, input ready);
  modport sink (input valid, input value, input last_of_sweep, output ready);
endinterface

`default_nettype wire

[rtl/core/fpss_cfg_if.sv]
// ----------------------------------------------------------------------------
// fpss_cfg_if
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fpss_cfg_if;
  import fpss_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ROWS_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/fpss_ram.sv]
// ----------------------------------------------------------------------------
// fpss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1026,
  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/core/fpss_scan.sv]
// ----------------------------------------------------------------------------
// fpss_scan
// Raster position counters over the padded grid, with interior/last flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpss_scan
  import fpss_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEFAULT,
  localparam int CW = $clog2(MAX_COLS + 2)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [COLS_W-1:0]    grid_cols,
  input  wire logic [ROWS_W-1:0]    grid_rows,
  input  wire logic                 advance,
  output logic      [CW-1:0]        col,
  output logic      [CW-1:0]        col_next,
  output scan_flags_t               flags
);

  localparam int EW = ((CW > COLS_W) ? CW : COLS_W) + 1;

  logic [ROW_POS_W-1:0] row;
  logic [ROW_POS_W-1:0] row_next;
  logic [EW-1:0]        cols_req;
  logic [EW-1:0]        cols_eff;
  logic [EW-1:0]        col_ext;
  logic [ROW_POS_W-1:0] rows_lim;
  logic                 row_end;

  // Clamp the sizes: zero acts as one, columns stop at the line length
  always_comb begin
    cols_req = EW'(grid_cols);
    if (cols_req == '0) begin
      cols_eff = EW'(1);
    end else if (cols_req > EW'(MAX_COLS)) begin
      cols_eff = EW'(MAX_COLS);
    end else begin
      cols_eff = cols_req;
    end
    rows_lim = (grid_rows == '0) ? ROW_POS_W'(2) : ROW_POS_W'(grid_rows) + ROW_POS_W'(1);
  end

  // Decode the current position
  always_comb begin
    col_ext       = EW'(col);
    row_end       = (col_ext >= cols_eff + EW'(1));
    flags.produce = (row >= ROW_POS_W'(2)) && (row <= rows_lim) &&
                    (col != '0) && (col_ext <= cols_eff);
    flags.last    = (row == rows_lim) && (col_ext == cols_eff);
    col_next      = row_end ? '0 : col + CW'(1);
    row_next      = row_end ? ((row >= rows_lim) ? '0 : row + ROW_POS_W'(1)) : row;
  end

  // Advance one position per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (advance) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Column never runs past the end of the line buffers
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    EW'(col) <= EW'(MAX_COLS + 1))
    else $error("column position beyond line buffer depth");

  // The grid wraps to the origin after its last row
  a_grid_wrap: assert property (@(posedge clk) disable iff (rst)
    advance && row_end && (row >= rows_lim) |=> (col == '0) && (row == '0))
    else $error("grid did not restart after its last row");

  // The last flag only marks an interior cell
  a_last_interior: assert property (@(posedge clk) disable iff (rst)
    flags.last && (row >= ROW_POS_W'(2)) |-> flags.produce)
    else $error("last flag outside the interior");

endmodule

`default_nettype wire

[rtl/core/fpss_calc.sv]
// ----------------------------------------------------------------------------
// fpss_calc
// Negated quarter of the four-neighbor sum, Q16.16, saturating on overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpss_calc
  import fpss_pkg::*;
(
  input  wire logic signed [SAMPLE_W-1:0] up,
  input  wire logic signed [SAMPLE_W-1:0] down,
  input  wire logic signed [SAMPLE_W-1:0] left,
  input  wire logic signed [SAMPLE_W-1:0] right,
  output logic      signed [SAMPLE_W-1:0] value
);

  localparam int SUM_W = SAMPLE_W + 2;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] quarter;

  // Exact sum, floor divide by four, negate with saturation
  always_comb begin
    sum     = SUM_W'(up) + SUM_W'(down) + SUM_W'(left) + SUM_W'(right);
    quarter = sum[SUM_W-1:2];
    value   = (quarter == S_MIN) ? S_MAX : -quarter;
  end

endmodule

`default_nettype wire

[rtl/core/five_point_stencil_sweep_top.sv]
// ----------------------------------------------------------------------------
// five_point_stencil_sweep_top
// Streaming five-point stencil over a padded grid with two line buffers.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                          | notes
//  ----------+-----+----------------------------------+---------------------------
//  samples   | in  | sample (s32 Q16.16)              | raster order, border incl.
//  results   | out | value (s32 Q16.16), last_of_sweep| one per interior cell
//  cfg       | in  | index (0 cols, 1 rows), data     | always ready
//
//  One sample per cycle unless a held result stalls; results register on transfer.
//  Line buffer reads are prefetched one position ahead from registered RAMs,
//  so throughput is bounded only by the output register.
//  A border sample is taken even while a result waits at the output.
//  Reset (rst, synchronous) clears position, registers and the output valid;
//  line buffers are not cleared and samples are refused while rst is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module five_point_stencil_sweep_top
  import fpss_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  fpss_cfg_if.sink    cfg,
  fpss_sample_if.sink samples,
  fpss_result_if.source results
);

  localparam int DEPTH = MAX_COLS + 2;
  localparam int CW    = $clog2(DEPTH);

  logic [COLS_W-1:0]          grid_cols;
  logic [ROWS_W-1:0]          grid_rows;
  logic [CW-1:0]              col;
  logic [CW-1:0]              col_next;
  logic [CW-1:0]              rd_col;
  scan_flags_t                flags;
  logic                       accept;
  logic [2*SAMPLE_W-1:0]      pair_rd;
  logic [SAMPLE_W-1:0]        right_rd;
  logic signed [SAMPLE_W-1:0] above;
  logic signed [SAMPLE_W-1:0] two_above;
  logic signed [SAMPLE_W-1:0] previous_sample;
  logic signed [SAMPLE_W-1:0] calc_value;
  logic signed [SAMPLE_W-1:0] value_r;
  logic                       last_r;
  logic                       out_valid;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= GRID_COLS_RESET;
      grid_rows <= GRID_ROWS_RESET;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_GRID_COLS: grid_cols <= cfg.data[COLS_W-1:0];
        REG_GRID_ROWS: grid_rows <= cfg.data;
        default: ;
      endcase
    end
  end

  // Sample transfer: refuse in reset or when a result would collide with a held one
  assign samples.ready = !rst && (!out_valid || results.ready || !flags.produce);
  assign accept        = samples.valid && samples.ready;

  fpss_scan #(.MAX_COLS(MAX_COLS)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .grid_cols (grid_cols),
    .grid_rows (grid_rows),
    .advance   (accept),
    .col       (col),
    .col_next  (col_next),
    .flags     (flags)
  );

  // Prefetch the line buffers for the position that comes next
  assign rd_col = rst ? '0 : (accept ? col_next : col);

  // Row above and row two above, packed in one entry, read at the column
  fpss_ram #(.WIDTH(2*SAMPLE_W), .DEPTH(DEPTH)) u_pair_ram (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col),
    .wr_data ({above, samples.sample}),
    .rd_addr (rd_col),
    .rd_data (pair_rd)
  );

  // Copy of the row above, read one column to the right
  fpss_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_right_ram (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col),
    .wr_data (samples.sample),
    .rd_addr (rd_col + CW'(1)),
    .rd_data (right_rd)
  );

  assign above     = pair_rd[SAMPLE_W-1:0];
  assign two_above = pair_rd[2*SAMPLE_W-1:SAMPLE_W];

  // Hold the row-above value of the previous column as the left neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
    end else if (accept) begin
      previous_sample <= above;
    end
  end

  fpss_calc u_calc (
    .up    (two_above),
    .down  (samples.sample),
    .left  (previous_sample),
    .right (right_rd),
    .value (calc_value)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && flags.produce) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && flags.produce) begin
      value_r <= calc_value;
      last_r  <= flags.last;
    end
  end

  assign results.valid         = out_valid;
  assign results.value         = value_r;
  assign results.last_of_sweep = last_r;

  // A held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !results.ready |-> !(accept && flags.produce))
    else $error("held result overwritten by a new one");

  // A result appears only after an interior sample transfer
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(accept && flags.produce))
    else $error("result without an interior sample");

  // Line buffer prefetch follows the scan position while stalled
  a_prefetch_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |-> rd_col == col)
    else $error("line buffer read address left the scan position");

endmodule

`default_nettype wire
